// ===== hdl/mm_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared sizes, request and register codes, and helpers for the fixed-point
// matrix multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

  // Storage and number format
  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

  // Port field widths
  localparam int CFG_W   = 4;
  localparam int REQ_W   = 2;
  localparam int POS_W   = 3;
  localparam int VAL_W   = 16;
  localparam int TDATA_W = 24;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Request codes (tuser on the input stream)
  localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  // Rounding offset: half an output step
  localparam logic signed [ACC_W-1:0] RND_HALF =
    (FRAC_BITS > 0) ? ACC_W'(64'(1) << (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0)) : '0;

  // Saturation limits of the element format
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'(1) << (DATA_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_ROUND
  } state_e;

  // Register value to effective dimension: zero acts as one, clamp to MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (32'(r) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(r);
    end
    return d;
  endfunction

endpackage

// ===== hdl/matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply
// Fixed-point C = A * B with A and B held in two RAMs and one shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Element writes (tuser 0 for A, 1 for B) are accepted back to back. A compute
// transaction (tuser 2) occupies the block until its last result is queued:
// every element of C takes inner_dim products through the single 16x16
// multiplier, then passes the RAM read, product register, accumulate and
// rounding steps. Results leave in row-major order from an output register,
// so the next element is computed while the current one waits. Effective
// dimensions clamp: a zero register acts as 1, values above 8 act as 8.
// Reading an element never written returns unspecified data.
// ----------------------------------------------------------------------------
module matrix_multiply (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mm_pkg::PADDR_W-1:0] paddr,
  input  logic [mm_pkg::PDATA_W-1:0] pwdata,
  output logic [mm_pkg::PDATA_W-1:0] prdata,
  output logic                       pready,

  // Request stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [2:0] row_index, [5:3] col_index, [21:6] elem_value, [23:22] zero
  input  logic [mm_pkg::TDATA_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [mm_pkg::REQ_W-1:0]   s_axis_tuser,

  // Result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [2:0] out_row, [5:3] out_col, [21:6] out_value, [23:22] zero
  output logic [mm_pkg::TDATA_W-1:0] m_axis_tdata,
  // [0] saturated
  output logic [0:0]                 m_axis_tuser,
  output logic                       m_axis_tlast
);

  localparam int DW     = mm_pkg::DATA_WIDTH;
  localparam int AW     = mm_pkg::ADDR_W;
  localparam int IW     = mm_pkg::IDX_W;
  localparam int NW     = mm_pkg::DIM_W;
  localparam int CW     = mm_pkg::CFG_W;
  localparam int PW     = mm_pkg::POS_W;
  localparam int VW     = mm_pkg::VAL_W;
  localparam int ACCW   = mm_pkg::ACC_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CW-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= CW'(8);
      inner_dim_q <= CW'(8);
      cols_b_q    <= CW'(8);
    end else if (cfg_wr) begin
      if (cfg_idx == mm_pkg::REG_ROWS_A)    rows_a_q    <= pwdata[CW-1:0];
      if (cfg_idx == mm_pkg::REG_INNER_DIM) inner_dim_q <= pwdata[CW-1:0];
      if (cfg_idx == mm_pkg::REG_COLS_B)    cols_b_q    <= pwdata[CW-1:0];
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      mm_pkg::REG_ROWS_A:    prdata = mm_pkg::PDATA_W'(rows_a_q);
      mm_pkg::REG_INNER_DIM: prdata = mm_pkg::PDATA_W'(inner_dim_q);
      mm_pkg::REG_COLS_B:    prdata = mm_pkg::PDATA_W'(cols_b_q);
      default:               prdata = '0;
    endcase
  end

  // Effective dimensions
  logic [NW-1:0] nr, nk, nc;
  assign nr = mm_pkg::eff_dim(rows_a_q);
  assign nk = mm_pkg::eff_dim(inner_dim_q);
  assign nc = mm_pkg::eff_dim(cols_b_q);

  // --------------------------------------------------------------------------
  // Input unpacking and element writes
  // --------------------------------------------------------------------------
  logic [PW-1:0]       in_row, in_col;
  logic signed [VW-1:0] in_val;
  logic                in_hs, in_range;
  logic [AW-1:0]       wr_addr;
  logic                a_we, b_we;
  logic [DW-1:0]       wr_data;

  assign in_row   = s_axis_tdata[PW-1:0];
  assign in_col   = s_axis_tdata[2*PW-1:PW];
  assign in_val   = s_axis_tdata[2*PW+VW-1:2*PW];
  assign in_hs    = s_axis_tvalid && s_axis_tready;
  assign in_range = (32'(in_row) < mm_pkg::MAX_DIM) && (32'(in_col) < mm_pkg::MAX_DIM);
  assign wr_addr  = AW'(in_row) * AW'(mm_pkg::MAX_DIM) + AW'(in_col);
  assign wr_data  = DW'(in_val);
  assign a_we     = in_hs && in_range && (s_axis_tuser == mm_pkg::REQ_WRITE_A);
  assign b_we     = in_hs && in_range && (s_axis_tuser == mm_pkg::REQ_WRITE_B);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  mm_pkg::state_e state_q, state_d;
  logic [IW-1:0]  y_q, y_d, x_q, x_d, e_q, e_d;
  logic           e_last, x_last, y_last, start;
  logic           out_vld_q, out_vld_d, out_free, load;
  logic           mul_vld_q, mul_last_q;

  assign e_last   = (NW'(e_q) + NW'(1)) == nk;
  assign x_last   = (NW'(x_q) + NW'(1)) == nc;
  assign y_last   = (NW'(y_q) + NW'(1)) == nr;
  assign start    = in_hs && (s_axis_tuser == mm_pkg::REQ_COMPUTE);
  assign out_free = !out_vld_q || m_axis_tready;
  assign load     = (state_q == mm_pkg::ST_ROUND) && out_free;

  // Ready only while idle
  assign s_axis_tready = (state_q == mm_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mm_pkg::ST_IDLE:  if (start) state_d = mm_pkg::ST_CALC;
      mm_pkg::ST_CALC:  if (e_last) state_d = mm_pkg::ST_DRAIN;
      mm_pkg::ST_DRAIN: if (mul_vld_q && mul_last_q) state_d = mm_pkg::ST_ROUND;
      mm_pkg::ST_ROUND: begin
        if (out_free) begin
          state_d = (x_last && y_last) ? mm_pkg::ST_IDLE : mm_pkg::ST_CALC;
        end
      end
      default:          state_d = mm_pkg::ST_IDLE;
    endcase
  end

  // Loop counters
  always_comb begin
    y_d = y_q;
    x_d = x_q;
    e_d = e_q;
    unique case (state_q)
      mm_pkg::ST_IDLE: begin
        if (start) begin
          y_d = '0;
          x_d = '0;
          e_d = '0;
        end
      end
      mm_pkg::ST_CALC: begin
        e_d = e_last ? '0 : e_q + IW'(1);
      end
      mm_pkg::ST_ROUND: begin
        if (out_free) begin
          if (x_last) begin
            x_d = '0;
            y_d = y_q + IW'(1);
          end else begin
            x_d = x_q + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mm_pkg::ST_IDLE;
      y_q     <= '0;
      x_q     <= '0;
      e_q     <= '0;
    end else begin
      state_q <= state_d;
      y_q     <= y_d;
      x_q     <= x_d;
      e_q     <= e_d;
    end
  end

  // --------------------------------------------------------------------------
  // Matrix storage
  // --------------------------------------------------------------------------
  logic [AW-1:0] a_raddr, b_raddr;
  logic [DW-1:0] a_rdata, b_rdata;

  assign a_raddr = AW'(y_q) * AW'(mm_pkg::MAX_DIM) + AW'(e_q);
  assign b_raddr = AW'(e_q) * AW'(mm_pkg::MAX_DIM) + AW'(x_q);

  mm_ram #(.WIDTH(DW), .DEPTH(mm_pkg::CELLS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mm_ram #(.WIDTH(DW), .DEPTH(mm_pkg::CELLS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // --------------------------------------------------------------------------
  // Multiply-accumulate pipeline: read, multiply, accumulate
  // --------------------------------------------------------------------------
  logic                      rd_vld_q, rd_first_q, rd_last_q;
  logic                      mul_first_q;
  logic signed [2*DW-1:0]    prod_q;
  logic signed [ACCW-1:0]    acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      mul_vld_q   <= 1'b0;
      mul_first_q <= 1'b0;
      mul_last_q  <= 1'b0;
    end else begin
      rd_vld_q    <= (state_q == mm_pkg::ST_CALC);
      rd_first_q  <= (e_q == '0);
      rd_last_q   <= e_last;
      mul_vld_q   <= rd_vld_q;
      mul_first_q <= rd_first_q;
      mul_last_q  <= rd_last_q;
    end
  end

  // Product register
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_rdata) * $signed(b_rdata);
  end

  // Accumulator, restarted on the first product of each element
  always_comb begin
    acc_d = acc_q;
    if (mul_vld_q) begin
      acc_d = (mul_first_q ? ACCW'(0) : acc_q) + ACCW'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // --------------------------------------------------------------------------
  // Round to nearest, saturate, and output register
  // --------------------------------------------------------------------------
  logic signed [ACCW-1:0] rnd_sum, rnd_shift;
  logic                   sat_hi, sat_lo;
  logic [DW-1:0]          rnd_val;

  assign rnd_sum   = acc_q + mm_pkg::RND_HALF;
  assign rnd_shift = rnd_sum >>> mm_pkg::FRAC_BITS;
  assign sat_hi    = rnd_shift > mm_pkg::SAT_HI;
  assign sat_lo    = rnd_shift < mm_pkg::SAT_LO;

  always_comb begin
    priority if (sat_hi) begin
      rnd_val = DW'(mm_pkg::SAT_HI);
    end else if (sat_lo) begin
      rnd_val = DW'(mm_pkg::SAT_LO);
    end else begin
      rnd_val = DW'(rnd_shift);
    end
  end

  logic [PW-1:0] out_row_q, out_col_q;
  logic [VW-1:0] out_val_q;
  logic          out_sat_q, out_last_q;

  assign out_vld_d = load ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_row_q  <= PW'(y_q);
      out_col_q  <= PW'(x_q);
      out_val_q  <= VW'(rnd_val);
      out_sat_q  <= sat_hi || sat_lo;
      out_last_q <= x_last && y_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_val_q, out_col_q, out_row_q};
  assign m_axis_tuser  = out_sat_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hdl/mm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
